[rtl/pshw_pkg.sv]
package pshw_pkg;

   localparam int SN_W     = 12;
   localparam int HFN_OUT_W = 32;
   localparam int CSR_AW   = 5;
   localparam int CSR_DW   = 32;

   localparam logic [3:0] SN_SIZE_SHORT = 4'd5;
   localparam logic [3:0] SN_SIZE_MID   = 4'd7;
   localparam logic [3:0] SN_SIZE_LONG  = 4'd12;

   localparam logic [1:0] MODE_AM = 2'd0;
   localparam logic [1:0] MODE_UM = 2'd1;

   localparam logic [2:0] REG_SN_SIZE        = 3'd0;
   localparam logic [2:0] REG_LINK_MODE      = 3'd1;
   localparam logic [2:0] REG_WINDOW_SMALL   = 3'd2;
   localparam logic [2:0] REG_WINDOW_LARGE   = 3'd3;
   localparam logic [2:0] REG_LAST_DELIVERED = 3'd4;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_SIZE = 3'd1,
      ST_RANGE    = 3'd2,
      ST_DISCARD  = 3'd3,
      ST_MODE     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ASSIGN,
      OP_REJECT,
      OP_FOLLOW,
      OP_WINDOW,
      OP_DISCARD,
      OP_UNSUPPORTED
   } op_type;

   typedef struct packed {
      logic [3:0]      sn_size;
      logic [1:0]      link_mode;
      logic [6:0]      window_small;
      logic [SN_W-1:0] window_large;
      logic [SN_W-1:0] last_delivered_sn;
   } cfg_type;

   typedef struct packed {
      op_type          op;
      status_type      status;
      logic            cmd;
      logic [SN_W-1:0] sn;
      logic            sn_top;
      logic [SN_W-1:0] top;
      logic [SN_W-1:0] window;
   } item_type;

   typedef struct packed {
      logic [SN_W-1:0]      tx_sn;
      status_type           status;
      logic                 accepted;
      logic                 hfn_offset;
      logic [HFN_OUT_W-1:0] hfn_value;
   } rsp_type;

endpackage

[rtl/pdcp_sn_hfn_window_manager_unit.sv]
// Channel   Dir  Handshake                 Payload
// req_      in   req_tvalid / req_tready   tdata: rx_sn; tuser: command, signalling_bearer
// rsp_      out  rsp_tvalid / rsp_tready   tdata: tx_sn, status, accepted, hfn_offset, hfn_value
// csr_      in   psel, penable, pwrite     five registers at byte address 4*i
//
// One word is accepted per cycle while the queue has room and the sweep is not running;
// rsp_tvalid rises once the word has passed the queue slot and the response register.
// The receive counters are updated by the back end as each word is taken from the queue.
// After reset the received bitmap is swept, one octet per cycle, until all MAP_OCTETS octets
// are cleared, while req_tready stays low; configuration writes are taken during the sweep.
// A two-word queue and the response register let either side stall independently.
module pdcp_sn_hfn_window_manager_unit #(
   parameter int SN_BITS_MAX = 12,
   parameter int MAP_OCTETS  = 512,
   parameter int HFN_WIDTH   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // rx_sn[11:0], zero pad
   input  logic [1:0]                    req_tuser,  // command, signalling_bearer
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tx_sn[11:0], status[14:12], accepted[15], hfn_offset[16], hfn_value[48:17], zero pad
   output logic [55:0]                   rsp_tdata,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pshw_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [pshw_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [pshw_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import pshw_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [2:0] reg_index;
   logic       map_clearing;
   logic       push_valid, push_ready;
   item_type   push_item;
   logic       pop_valid, pop_ready;
   item_type   pop_item;
   rsp_type    rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_SN_SIZE:        cfg_in.sn_size           = csr_pwdata[3:0];
            REG_LINK_MODE:      cfg_in.link_mode         = csr_pwdata[1:0];
            REG_WINDOW_SMALL:   cfg_in.window_small      = csr_pwdata[6:0];
            REG_WINDOW_LARGE:   cfg_in.window_large      = csr_pwdata[SN_W-1:0];
            REG_LAST_DELIVERED: cfg_in.last_delivered_sn = csr_pwdata[SN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SN_SIZE:        csr_prdata = CSR_DW'(cfg_ff.sn_size);
         REG_LINK_MODE:      csr_prdata = CSR_DW'(cfg_ff.link_mode);
         REG_WINDOW_SMALL:   csr_prdata = CSR_DW'(cfg_ff.window_small);
         REG_WINDOW_LARGE:   csr_prdata = CSR_DW'(cfg_ff.window_large);
         REG_LAST_DELIVERED: csr_prdata = CSR_DW'(cfg_ff.last_delivered_sn);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sn_size           <= SN_SIZE_LONG;
         cfg_ff.link_mode         <= MODE_AM;
         cfg_ff.window_small      <= 7'd64;
         cfg_ff.window_large      <= 12'd2048;
         cfg_ff.last_delivered_sn <= 12'd4095;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pshw_front u_front (
      .in_valid             (req_tvalid),
      .in_ready             (req_tready),
      .in_command           (req_tuser[0]),
      .in_rx_sn             (req_tdata[11:0]),
      .in_signalling_bearer (req_tuser[1]),
      .cfg                  (cfg_ff),
      .map_clearing         (map_clearing),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_item            (push_item)
   );

   pshw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   pshw_back #(
      .SN_BITS_MAX (SN_BITS_MAX),
      .MAP_OCTETS  (MAP_OCTETS),
      .HFN_WIDTH   (HFN_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .item         (pop_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp          (rsp),
      .map_clearing (map_clearing)
   );

   assign rsp_tdata = {7'd0, rsp.hfn_value, rsp.hfn_offset, rsp.accepted, rsp.status, rsp.tx_sn};

endmodule

[rtl/pshw_front.sv]
module pshw_front (
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               in_command,
   input  logic [11:0]        in_rx_sn,
   input  logic               in_signalling_bearer,
   input  pshw_pkg::cfg_type  cfg,
   input  logic               map_clearing,
   output logic               push_valid,
   input  logic               push_ready,
   output pshw_pkg::item_type push_item
);
   import pshw_pkg::*;

   localparam int FW = SN_W + 2;

   logic                 size_ok;
   logic [SN_W-1:0]      top;
   logic [SN_W-1:0]      window;
   logic signed [FW-1:0] s_v;
   logic signed [FW-1:0] last_v;
   logic signed [FW-1:0] win_v;
   logic signed [FW-1:0] ahead;
   logic signed [FW-1:0] behind;
   logic                 discard;

   assign in_ready   = push_ready && !map_clearing;
   assign push_valid = in_valid && !map_clearing;

   always_comb begin
      unique case (cfg.sn_size)
         SN_SIZE_SHORT, SN_SIZE_MID, SN_SIZE_LONG: size_ok = 1'b1;
         default: size_ok = 1'b0;
      endcase
      top    = size_ok ? ((SN_W'(1) << cfg.sn_size) - SN_W'(1)) : '0;
      window = (cfg.sn_size == SN_SIZE_MID) ? SN_W'(cfg.window_small) : cfg.window_large;
      s_v    = FW'(in_rx_sn);
      last_v = FW'(cfg.last_delivered_sn);
      win_v  = FW'(window);
      ahead  = s_v - last_v;
      behind = last_v - s_v;
      discard = (ahead > win_v) || ((behind >= 0) && (behind < win_v));
   end

   always_comb begin
      push_item.cmd    = in_command;
      push_item.sn     = in_rx_sn;
      push_item.sn_top = (in_rx_sn == top);
      push_item.top    = top;
      push_item.window = window;
      push_item.op     = OP_REJECT;
      push_item.status = ST_OK;
      if (!in_command) begin
         if (size_ok) begin
            push_item.op = OP_ASSIGN;
         end else begin
            push_item.status = ST_BAD_SIZE;
         end
      end else if (!size_ok) begin
         push_item.status = ST_BAD_SIZE;
      end else if (in_rx_sn > top) begin
         push_item.status = ST_RANGE;
      end else if (in_signalling_bearer) begin
         push_item.op = OP_FOLLOW;
      end else begin
         unique case (cfg.link_mode)
            MODE_AM: begin
               if (discard) begin
                  push_item.op     = OP_DISCARD;
                  push_item.status = ST_DISCARD;
               end else begin
                  push_item.op = OP_WINDOW;
               end
            end
            MODE_UM: push_item.op = OP_FOLLOW;
            default: begin
               push_item.op     = OP_UNSUPPORTED;
               push_item.status = ST_MODE;
            end
         endcase
      end
   end

endmodule

[rtl/pshw_queue.sv]
module pshw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  pshw_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output pshw_pkg::item_type pop_item
);
   import pshw_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/pshw_back.sv]
module pshw_back #(
   parameter int SN_BITS_MAX = 12,
   parameter int MAP_OCTETS  = 512,
   parameter int HFN_WIDTH   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  pshw_pkg::item_type item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pshw_pkg::rsp_type  rsp,
   output logic               map_clearing
);
   import pshw_pkg::*;

   localparam int SNW = SN_BITS_MAX;
   localparam int CW  = (SN_BITS_MAX > SN_W) ? SN_BITS_MAX : SN_W;
   localparam int DW  = CW + 2;
   localparam int AW  = (MAP_OCTETS > 1) ? $clog2(MAP_OCTETS) : 1;
   localparam logic [AW-1:0] CLR_LAST = AW'(MAP_OCTETS - 1);

   logic [SNW-1:0]       next_tx_ff, next_tx_in;
   logic [SNW-1:0]       next_rx_ff, next_rx_in;
   logic [HFN_WIDTH-1:0] tx_hfn_ff, tx_hfn_in;
   logic [HFN_WIDTH-1:0] rx_hfn_ff, rx_hfn_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 clearing_ff, clearing_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [7:0]           map_mem [MAP_OCTETS];

   logic                 take;
   logic signed [DW-1:0] sn_s, nxt_s, win_s, d_ns, d_sn;
   logic [SN_W:0]        sn_inc;
   logic [SNW-1:0]       follow_next;
   logic [CW-1:0]        tx_ext;
   logic                 tx_at_top;
   logic [1:0]           top_inc;
   logic [1:0]           rx_add;
   logic                 offset;
   logic [SN_W-1:0]      tx_sn_v;
   logic                 mark;
   logic [SN_W-4:0]      oct_full;
   logic                 oct_in_range;
   logic [AW-1:0]        oct_idx;

   assign pop_ready    = (!rsp_valid_ff || rsp_ready) && !clearing_ff;
   assign take         = pop_valid && pop_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp          = rsp_ff;
   assign map_clearing = clearing_ff;

   assign sn_s        = DW'(item.sn);
   assign nxt_s       = DW'(next_rx_ff);
   assign win_s       = DW'(item.window);
   assign d_ns        = nxt_s - sn_s;
   assign d_sn        = sn_s - nxt_s;
   assign sn_inc      = (SN_W + 1)'(item.sn) + (SN_W + 1)'(1);
   assign follow_next = item.sn_top ? '0 : SNW'(sn_inc);
   assign tx_ext      = CW'(next_tx_ff);
   assign tx_at_top   = (tx_ext == CW'(item.top));
   assign top_inc     = {1'b0, item.sn_top};

   assign mark = (item.op == OP_FOLLOW) || (item.op == OP_WINDOW) ||
                 (item.op == OP_DISCARD) || (item.op == OP_UNSUPPORTED);
   assign oct_full     = item.sn[SN_W-1:3];
   assign oct_in_range = (32'(oct_full) < 32'(MAP_OCTETS));
   assign oct_idx      = AW'(oct_full);

   always_comb begin
      next_tx_in   = next_tx_ff;
      next_rx_in   = next_rx_ff;
      tx_hfn_in    = tx_hfn_ff;
      rx_add       = 2'd0;
      offset       = 1'b0;
      tx_sn_v      = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         case (item.op)
            OP_ASSIGN: begin
               tx_sn_v = tx_ext[SN_W-1:0];
               if (tx_at_top) begin
                  next_tx_in = '0;
                  tx_hfn_in  = tx_hfn_ff + HFN_WIDTH'(1);
               end else begin
                  next_tx_in = next_tx_ff + SNW'(1);
               end
            end
            OP_FOLLOW: begin
               rx_add     = 2'(sn_s < nxt_s) + top_inc;
               next_rx_in = follow_next;
            end
            OP_WINDOW: begin
               if (d_ns > win_s) begin
                  rx_add     = 2'd1 + top_inc;
                  next_rx_in = follow_next;
               end else if (d_sn >= win_s) begin
                  offset = 1'b1;
               end else if (sn_s >= nxt_s) begin
                  rx_add     = top_inc;
                  next_rx_in = follow_next;
               end
            end
            OP_DISCARD: offset = (sn_s > nxt_s);
            default: ;
         endcase
         rsp_valid_in      = 1'b1;
         rsp_in.tx_sn      = tx_sn_v;
         rsp_in.status     = item.status;
         rsp_in.accepted   = (item.status == ST_OK);
         rsp_in.hfn_offset = offset;
      end
      rx_hfn_in = rx_hfn_ff + HFN_WIDTH'(rx_add);
      if (take) begin
         rsp_in.hfn_value = item.cmd ? HFN_OUT_W'(rx_hfn_in) : HFN_OUT_W'(tx_hfn_in);
      end
      clearing_in = clearing_ff && (clr_cnt_ff != CLR_LAST);
      clr_cnt_in  = clearing_ff ? clr_cnt_ff + AW'(1) : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_tx_ff   <= '0;
         next_rx_ff   <= '0;
         tx_hfn_ff    <= '0;
         rx_hfn_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         next_tx_ff   <= next_tx_in;
         next_rx_ff   <= next_rx_in;
         tx_hfn_ff    <= tx_hfn_in;
         rx_hfn_ff    <= rx_hfn_in;
         rsp_valid_ff <= rsp_valid_in;
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         map_mem[clr_cnt_ff] <= '0;
      end else if (take && mark && oct_in_range) begin
         map_mem[oct_idx][item.sn[2:0]] <= 1'b1;
      end
   end

endmodule
